// ===== design/sync_checksum_packet_deframer_macros.svh =====
// Assertion macros for the packet deframer.
// Included by the top level; no other dependencies.
`ifndef SYNC_CHECKSUM_PACKET_DEFRAMER_MACROS_SVH
`define SYNC_CHECKSUM_PACKET_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define SCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SCD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define SCD_ASSERT(lbl, prop, msg)
`define SCD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/scd_pkg.sv =====
// Shared types and constants for the packet deframer.
// No dependencies.
package scd_pkg;

  localparam int unsigned KeptLen   = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] FirstSyncReset  = 8'd170;
  localparam logic [7:0] SecondSyncReset = 8'd85;
  localparam logic [8:0] TypeLimitReset  = 9'd16;

  localparam logic [2:0] PosSync1 = 3'd0;
  localparam logic [2:0] PosSync2 = 3'd1;
  localparam logic [2:0] PosType  = 3'd2;
  localparam logic [2:0] PosCheck = 3'd7;
  localparam logic [2:0] PosData0 = 3'd3;

  localparam logic [1:0] ReqByte  = 2'd0;
  localparam logic [1:0] ReqFetch = 2'd1;
  localparam logic [1:0] ReqAck   = 2'd2;

  typedef enum logic [1:0] {
    REG_FIRST_SYNC  = 2'd0,
    REG_SECOND_SYNC = 2'd1,
    REG_TYPE_LIMIT  = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_FETCH  = 2'd1,
    OP_ACK    = 2'd2,
    OP_IGNORE = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_out_t;

  typedef struct packed {
    logic [7:0] first_sync;
    logic [7:0] second_sync;
    logic [8:0] type_limit;
  } cfg_t;

endpackage

// ===== design/scd_front.sv =====
// Front end: accepts requests, decodes them and queues them for the back end.
// Depends on scd_pkg.
module scd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          rx_byte_i,
  output scd_pkg::front_out_t front_o,
  input  logic                pop_i
);

  localparam int unsigned PtrW = $clog2(scd_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(scd_pkg::QueueDepth + 1);

  scd_pkg::item_t      entry_q [scd_pkg::QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  scd_pkg::op_e        op;
  logic                push, pop;

  always_comb begin
    unique case (req_type_i)
      scd_pkg::ReqByte:  op = scd_pkg::OP_BYTE;
      scd_pkg::ReqFetch: op = scd_pkg::OP_FETCH;
      scd_pkg::ReqAck:   op = scd_pkg::OP_ACK;
      default:           op = scd_pkg::OP_IGNORE;
    endcase
  end

  assign in_stall_o = (count_q == CntW'(scd_pkg::QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(scd_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(scd_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{op: op, rx_byte: rx_byte_i};
    end
  end

  assign front_o.valid = (count_q != '0);
  assign front_o.item  = entry_q[rd_ptr_q];

endmodule

// ===== design/scd_back.sv =====
// Back end: frame parser, holding slot and registered result stage.
// Depends on scd_pkg.
module scd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scd_pkg::cfg_t       cfg_i,
  input  scd_pkg::front_out_t front_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                slot_full_o,
  output logic                fetched_o,
  output logic [7:0]          packet_kind_o,
  output logic [7:0]          payload_a_o,
  output logic [7:0]          payload_b_o,
  output logic [7:0]          payload_c_o,
  output logic [7:0]          payload_d_o
);

  logic [2:0] pos_q, pos_d;
  logic [7:0] asm_q  [scd_pkg::KeptLen];
  logic [7:0] held_q [scd_pkg::KeptLen];
  logic [7:0] sum_q, sum_d;
  logic       held_valid_q, held_valid_d;
  logic       out_valid_q;
  logic       ready, take;
  logic       is_byte, asm_we, hold_we, do_fetch;
  logic [2:0] asm_idx;
  logic [7:0] b;

  assign ready   = !out_valid_q || !out_stall_i;
  assign take    = ready && front_i.valid;
  assign pop_o   = ready;
  assign b       = front_i.item.rx_byte;
  assign is_byte = take && (front_i.item.op == scd_pkg::OP_BYTE);
  assign asm_idx = pos_q - scd_pkg::PosType;

  always_comb begin
    pos_d        = pos_q;
    sum_d        = sum_q;
    held_valid_d = held_valid_q;
    asm_we       = 1'b0;
    hold_we      = 1'b0;
    do_fetch     = 1'b0;
    if (take) begin
      case (front_i.item.op)
        scd_pkg::OP_BYTE: begin
          case (pos_q)
            scd_pkg::PosSync1: pos_d = (b == cfg_i.first_sync) ? scd_pkg::PosSync2
                                                               : scd_pkg::PosSync1;
            scd_pkg::PosSync2: pos_d = (b == cfg_i.second_sync) ? scd_pkg::PosType
                                                                : scd_pkg::PosSync1;
            scd_pkg::PosType: begin
              if ({1'b0, b} < cfg_i.type_limit) begin
                asm_we = 1'b1;
                pos_d  = scd_pkg::PosData0;
              end else begin
                pos_d = scd_pkg::PosSync1;
              end
            end
            scd_pkg::PosCheck: begin
              if (sum_q == b && !held_valid_q) begin
                hold_we      = 1'b1;
                held_valid_d = 1'b1;
              end
              pos_d = scd_pkg::PosSync1;
            end
            default: begin
              asm_we = 1'b1;
              sum_d  = (pos_q == scd_pkg::PosData0) ? b : sum_q + b;
              pos_d  = pos_q + 3'd1;
            end
          endcase
        end
        scd_pkg::OP_FETCH: begin
          if (held_valid_q) begin
            do_fetch     = 1'b1;
            held_valid_d = 1'b0;
          end
        end
        scd_pkg::OP_ACK: held_valid_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= scd_pkg::PosSync1;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      held_valid_q <= held_valid_d;
      if (ready) begin
        out_valid_q <= front_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (is_byte && asm_we) begin
      asm_q[asm_idx] <= b;
    end
    if (hold_we) begin
      held_q <= asm_q;
    end
    if (take) begin
      slot_full_o   <= held_valid_d;
      fetched_o     <= do_fetch;
      packet_kind_o <= do_fetch ? held_q[0] : 8'd0;
      payload_a_o   <= do_fetch ? held_q[1] : 8'd0;
      payload_b_o   <= do_fetch ? held_q[2] : 8'd0;
      payload_c_o   <= do_fetch ? held_q[3] : 8'd0;
      payload_d_o   <= do_fetch ? held_q[4] : 8'd0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/sync_checksum_packet_deframer.sv =====
// Top level of the packet deframer: APB registers, front end and back end.
// Depends on scd_pkg, scd_front, scd_back and the assertion macro header.
//
//  channel | handshake               | payload
//  in      | in_valid_i / in_stall_o | req_type_i, rx_byte_i
//  out     | out_valid_o / out_stall_i | slot_full_o, fetched_o, packet_kind_o,
//          |                         | payload_a_o .. payload_d_o
//  cfg     | psel/penable/pwrite     | paddr, pwdata, prdata
//
// One request per cycle while in_stall_o is low; a taken request enters the two-entry
// queue, is parsed by the back end and its result is registered onto the outputs.
// The queue absorbs output stalls; in_stall_o rises only when both entries are full.
// Reset clears the parser position, the slot flag, the queue and the output valid;
// configuration returns to sync 0xAA, 0x55 and a type limit of 16.
`include "sync_checksum_packet_deframer_macros.svh"
module sync_checksum_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        slot_full_o,
  output logic        fetched_o,
  output logic [7:0]  packet_kind_o,
  output logic [7:0]  payload_a_o,
  output logic [7:0]  payload_b_o,
  output logic [7:0]  payload_c_o,
  output logic [7:0]  payload_d_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  scd_pkg::cfg_t       cfg_q;
  scd_pkg::front_out_t front;
  scd_pkg::reg_idx_e   reg_idx;
  logic                pop;
  logic                wr_en;
  logic                data_zero;

  assign pready  = 1'b1;
  assign reg_idx = scd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_sync  <= scd_pkg::FirstSyncReset;
      cfg_q.second_sync <= scd_pkg::SecondSyncReset;
      cfg_q.type_limit  <= scd_pkg::TypeLimitReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        scd_pkg::REG_FIRST_SYNC:  cfg_q.first_sync  <= pwdata[7:0];
        scd_pkg::REG_SECOND_SYNC: cfg_q.second_sync <= pwdata[7:0];
        scd_pkg::REG_TYPE_LIMIT:  cfg_q.type_limit  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      scd_pkg::REG_FIRST_SYNC:  prdata = {24'd0, cfg_q.first_sync};
      scd_pkg::REG_SECOND_SYNC: prdata = {24'd0, cfg_q.second_sync};
      scd_pkg::REG_TYPE_LIMIT:  prdata = {23'd0, cfg_q.type_limit};
      default:                  prdata = 32'd0;
    endcase
  end

  scd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .rx_byte_i  (rx_byte_i),
    .front_o    (front),
    .pop_i      (pop)
  );

  scd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .front_i       (front),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .slot_full_o   (slot_full_o),
    .fetched_o     (fetched_o),
    .packet_kind_o (packet_kind_o),
    .payload_a_o   (payload_a_o),
    .payload_b_o   (payload_b_o),
    .payload_c_o   (payload_c_o),
    .payload_d_o   (payload_d_o)
  );

  assign data_zero = ({packet_kind_o, payload_a_o, payload_b_o, payload_c_o, payload_d_o}
                      == 40'd0);

  `SCD_ASSERT(a_fetch_empties_slot, (out_valid_o && fetched_o) |-> !slot_full_o, "slot full")
  `SCD_ASSERT(a_idle_fields_zero, (out_valid_o && !fetched_o) |-> data_zero, "data without fetch")
  `SCD_ASSERT_ALWAYS(a_stall_needs_work, in_stall_o |-> front.valid, "stall with empty queue")

endmodule
